### hw/rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, constants and helpers for the keypad debounce window block.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int ROW_COUNT     = 4;
    localparam int COLUMN_COUNT  = 3;

    localparam int INPUT_ROWS    = 4;
    localparam int INPUT_COLS    = 3;

    localparam int KEY_W         = 4;
    localparam int CFG_W         = 4;
    localparam int NUM_KEYS      = ROW_COUNT * COLUMN_COUNT;
    localparam int SNAP_W        = ROW_COUNT * COLUMN_COUNT;
    localparam int POS_W         = (SNAP_W > 1) ? $clog2(SNAP_W) : 1;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int WIN_W         = $clog2(HISTORY_DEPTH + 1);

    localparam logic [CFG_W-1:0] CHECK_WINDOW_RESET = CFG_W'(5);

    localparam logic FUNC_SCAN  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        KS_NONE     = 2'd0,
        KS_RELEASED = 2'd1,
        KS_PRESSED  = 2'd2,
        KS_TRANS    = 2'd3
    } t_key_state;

    typedef enum logic {
        WALK_IDLE = 1'b0,
        WALK_RUN  = 1'b1
    } t_walk_state;

    typedef struct packed {
        logic              go;
        logic [POS_W-1:0]  pos;
        logic [WIN_W-1:0]  win;
        logic [SLOT_W-1:0] slot;
    } t_walk_req;

    typedef struct packed {
        logic       busy;
        logic       done;
        t_key_state state;
    } t_walk_rsp;

    // Bit position of a valid key (1 .. NUM_KEYS) within a snapshot; a small
    // constant lookup over the key range, zero for keys outside it
    function automatic logic [POS_W-1:0] key_pos(input logic [KEY_W-1:0] key);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int k = 1; k <= NUM_KEYS; k++) begin
            if (key == KEY_W'(k)) begin
                pos = POS_W'((ROW_COUNT - 1 - (k - 1) / COLUMN_COUNT) * COLUMN_COUNT
                             + (k - 1) % COLUMN_COUNT);
            end
        end
        return pos;
    endfunction

    // Clamp the window register to 1 .. HISTORY_DEPTH
    function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_W-1:0] cfg);
        int w;
        w = int'(cfg);
        if (w < 1) begin
            w = 1;
        end
        if (w > HISTORY_DEPTH) begin
            w = HISTORY_DEPTH;
        end
        return WIN_W'(w);
    endfunction

endpackage

### hw/rtl/kpd_walker.sv
// ----------------------------------------------------------------------------
// kpd_walker
// Walks the newest window entries of the history ring, one entry per cycle,
// and classifies one key bit as released, pressed or transitioning.
// ----------------------------------------------------------------------------
module kpd_walker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kpd_pkg::t_walk_req        i_req,
    input  logic                      i_bit,
    output logic [kpd_pkg::SLOT_W-1:0] o_slot,
    output logic [kpd_pkg::POS_W-1:0]  o_pos,
    output kpd_pkg::t_walk_rsp        o_rsp
);

    kpd_pkg::t_walk_state r_state, n_state;
    logic [kpd_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [kpd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [kpd_pkg::WIN_W-1:0]  r_cnt, n_cnt;
    logic                       r_seen_off, n_seen_off;
    logic                       r_seen_on, n_seen_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpd_pkg::WALK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_seen_off <= n_seen_off;
        r_seen_on  <= n_seen_on;
    end

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_seen_off = r_seen_off;
        n_seen_on  = r_seen_on;
        o_rsp.busy  = 1'b0;
        o_rsp.done  = 1'b0;
        o_rsp.state = kpd_pkg::KS_TRANS;

        unique case (r_state)
            kpd_pkg::WALK_IDLE: begin
                if (i_req.go) begin
                    n_state    = kpd_pkg::WALK_RUN;
                    n_slot     = i_req.slot;
                    n_pos      = i_req.pos;
                    n_cnt      = i_req.win;
                    n_seen_off = 1'b0;
                    n_seen_on  = 1'b0;
                end
            end
            kpd_pkg::WALK_RUN: begin
                o_rsp.busy = 1'b1;
                n_seen_off = r_seen_off | i_bit;
                n_seen_on  = r_seen_on | ~i_bit;
                // step back to the next older entry
                if (r_slot == '0) begin
                    n_slot = kpd_pkg::SLOT_W'(kpd_pkg::HISTORY_DEPTH - 1);
                end else begin
                    n_slot = r_slot - 1'b1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == kpd_pkg::WIN_W'(1)) begin
                    n_state    = kpd_pkg::WALK_IDLE;
                    o_rsp.done = 1'b1;
                    priority if (!n_seen_on) begin
                        o_rsp.state = kpd_pkg::KS_RELEASED;
                    end else if (!n_seen_off) begin
                        o_rsp.state = kpd_pkg::KS_PRESSED;
                    end else begin
                        o_rsp.state = kpd_pkg::KS_TRANS;
                    end
                end
            end
            default: begin
                n_state = kpd_pkg::WALK_IDLE;
            end
        endcase
    end

    assign o_slot = r_slot;
    assign o_pos  = r_pos;

endmodule

### hw/rtl/keypad_scan_debounce_window_core.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce_window_core
// Function: a scan word is stored at its accept edge and answers nothing; a
// query walks window history entries (window = check_window clamped to 1..8)
// and then answers; an out-of-range key answers without a walk.
// Throughput: scans every cycle while not busy; a query holds busy while the
// walker reads one history entry per cycle. Results cannot be stalled.
// Reset: history reads all released, write slot 0, check_window 5.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_window_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [2:0]                 i_row_0_bits,
    input  logic [2:0]                 i_row_1_bits,
    input  logic [2:0]                 i_row_2_bits,
    input  logic [2:0]                 i_row_3_bits,
    input  logic [kpd_pkg::KEY_W-1:0]  i_key_number,
    input  logic                       i_cfg_we,
    input  logic [kpd_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                       o_valid,
    output logic [1:0]                 o_key_state
);

    logic [kpd_pkg::CFG_W-1:0]  r_check_window;
    logic [kpd_pkg::SLOT_W-1:0] r_wslot, n_wslot;
    logic [kpd_pkg::SNAP_W-1:0] r_hist [kpd_pkg::HISTORY_DEPTH];
    logic [kpd_pkg::SNAP_W-1:0] snap;
    logic [kpd_pkg::INPUT_COLS-1:0] rows_in [kpd_pkg::INPUT_ROWS];
    logic                       r_out_valid, n_out_valid;
    kpd_pkg::t_key_state        r_out_state, n_out_state;

    logic                       accept, scan_acc, query_acc, key_ok;
    kpd_pkg::t_walk_req         walk_req;
    kpd_pkg::t_walk_rsp         walk_rsp;
    logic [kpd_pkg::SLOT_W-1:0] rd_slot;
    logic [kpd_pkg::POS_W-1:0]  rd_pos;
    logic [kpd_pkg::SNAP_W-1:0] rd_entry;
    logic                       rd_bit;

    assign busy      = walk_rsp.busy;
    assign accept    = start & ~busy;
    assign scan_acc  = accept & (i_func == kpd_pkg::FUNC_SCAN);
    assign query_acc = accept & (i_func == kpd_pkg::FUNC_QUERY);
    assign key_ok    = (int'(i_key_number) >= 1) && (int'(i_key_number) <= kpd_pkg::NUM_KEYS);

    assign rows_in[0] = i_row_0_bits;
    assign rows_in[1] = i_row_1_bits;
    assign rows_in[2] = i_row_2_bits;
    assign rows_in[3] = i_row_3_bits;

    // Rows or columns with no input stay released
    always_comb begin
        snap = '1;
        for (int r = 0; r < kpd_pkg::ROW_COUNT; r++) begin
            for (int c = 0; c < kpd_pkg::COLUMN_COUNT; c++) begin
                if (r < kpd_pkg::INPUT_ROWS && c < kpd_pkg::INPUT_COLS) begin
                    snap[r * kpd_pkg::COLUMN_COUNT + c] =
                        rows_in[r % kpd_pkg::INPUT_ROWS][c % kpd_pkg::INPUT_COLS];
                end
            end
        end
    end

    // Advance the write slot, then store into it
    always_comb begin
        if (r_wslot == kpd_pkg::SLOT_W'(kpd_pkg::HISTORY_DEPTH - 1)) begin
            n_wslot = '0;
        end else begin
            n_wslot = r_wslot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_window <= kpd_pkg::CHECK_WINDOW_RESET;
            r_wslot        <= '0;
            for (int i = 0; i < kpd_pkg::HISTORY_DEPTH; i++) begin
                r_hist[i] <= '1;
            end
        end else begin
            if (i_cfg_we) begin
                r_check_window <= i_cfg_wdata;
            end
            if (scan_acc) begin
                r_wslot         <= n_wslot;
                r_hist[n_wslot] <= snap;
            end
        end
    end

    assign walk_req.go   = query_acc & key_ok;
    assign walk_req.pos  = kpd_pkg::key_pos(i_key_number);
    assign walk_req.win  = kpd_pkg::clamp_window(r_check_window);
    assign walk_req.slot = r_wslot;

    assign rd_entry = r_hist[rd_slot];
    assign rd_bit   = rd_entry[rd_pos];

    kpd_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (walk_req),
        .i_bit   (rd_bit),
        .o_slot  (rd_slot),
        .o_pos   (rd_pos),
        .o_rsp   (walk_rsp)
    );

    // Result word register: an invalid key answers at once, otherwise the walker
    always_comb begin
        n_out_valid = 1'b0;
        n_out_state = kpd_pkg::KS_NONE;
        priority if (walk_rsp.done) begin
            n_out_valid = 1'b1;
            n_out_state = walk_rsp.state;
        end else if (query_acc && !key_ok) begin
            n_out_valid = 1'b1;
            n_out_state = kpd_pkg::KS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_state <= n_out_state;
    end

    assign o_valid     = r_out_valid;
    assign o_key_state = r_out_state;

endmodule
